// File: hdl/fnr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fnr_pkg
// Shared types, constants and helpers of the Newton a-th root core.
// ----------------------------------------------------------------------------
package fnr_pkg;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SUB,
        OP_DIV
    } t_fpu_op;

    typedef enum logic [2:0] {
        F_IDLE,
        F_UNPACK,
        F_EXEC,
        F_NORM,
        F_ROUND
    } t_fpu_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POW,
        S_FULL,
        S_NUM,
        S_DEN,
        S_DIV,
        S_CHECK,
        S_UPD,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic        go;
        t_fpu_op     op;
        logic [31:0] opa;
        logic [31:0] opb;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_fpu_rsp;

    localparam logic [31:0] FP_ONE       = 32'h3F80_0000;
    localparam logic [31:0] FP_INF       = 32'h7F80_0000;
    localparam logic [31:0] FP_QNAN_POS  = 32'h7FC0_0000;
    localparam logic [31:0] FP_QNAN_DEF  = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;
    // smallest single above 1e-4 (double)
    localparam logic [31:0] ERR_MIN      = 32'h38D1_B718;
    localparam int          NEWTON_LIMIT = 8;
    localparam int          DIV_STEPS    = 26;

    // small unsigned integer to single precision (exact)
    function automatic logic [31:0] int_to_fp(input logic [6:0] v);
        logic [31:0] r;
        int          p;
        r = '0;
        p = 0;
        for (int i = 0; i < 7; i++) begin
            if (v[i]) begin
                p = i;
            end
        end
        if (v != '0) begin
            r = {1'b0, 8'(127 + p), 23'(32'(v) << (23 - p))};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/float_nth_root_newton_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float_nth_root_newton_core
// Single-precision a-th root by Newton iteration on one shared FP unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the result has been shown. The root appears on o_root_value for one
// cycle with o_valid and must be taken then, the receiver cannot stall it.
// All arithmetic runs on the shared multiply/subtract/divide unit, one
// operation at a time. At most nine error evaluations and eight updates run
// before the result strobes. Zero degree or zero radicand strobes the result
// in the cycle right after acceptance.
// ----------------------------------------------------------------------------
module float_nth_root_newton_core
    import fnr_pkg::*;
#(
    parameter int MAX_EXPONENT = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_radicand,
    input  wire logic [4:0]  i_root_degree,
    output logic             o_valid,
    output logic [31:0]      o_root_value
);

    localparam int DW = $clog2(MAX_EXPONENT + 1);

    t_seq_state  r_state, n_state;
    logic        r_wait;
    logic [DW-1:0] r_deg, r_k, deg_sat;
    logic [3:0]  r_passes;
    logic [31:0] r_x, r_y, r_acc, r_full, r_num, r_den, r_err, r_afl;
    t_fpu_req    w_req;
    t_fpu_rsp    w_rsp;
    logic        accept, pow_done, err_big, op_state;

    fnr_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        accept   = start && !busy;
        deg_sat  = (32'(i_root_degree) > MAX_EXPONENT) ? DW'(MAX_EXPONENT)
                                                        : DW'(i_root_degree);
        pow_done = (r_k == r_deg - DW'(1));
        err_big  = (r_err[30:0] >= ERR_MIN[30:0]) && (r_err[30:0] <= FP_INF[30:0]);
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (deg_sat == '0 || i_radicand[30:0] == '0) ? S_DONE : S_POW;
                end
            end
            S_POW:   if (pow_done) n_state = S_FULL;
            S_FULL:  if (w_rsp.done) n_state = S_NUM;
            S_NUM:   if (w_rsp.done) n_state = S_DEN;
            S_DEN:   if (w_rsp.done) n_state = S_DIV;
            S_DIV:   if (w_rsp.done) n_state = S_CHECK;
            S_CHECK: n_state = (err_big && r_passes < 4'(NEWTON_LIMIT)) ? S_UPD : S_DONE;
            S_UPD:   if (w_rsp.done) n_state = S_POW;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs ----
    always_comb begin
        busy         = (r_state != S_IDLE);
        o_valid      = (r_state == S_DONE);
        o_root_value = r_y;
        op_state     = 1'b1;
        w_req.op     = OP_MUL;
        w_req.opa    = r_acc;
        w_req.opb    = r_y;
        unique case (r_state)
            S_POW:   op_state = !pow_done;
            S_FULL:  op_state = 1'b1;
            S_NUM: begin
                w_req.op  = OP_SUB;
                w_req.opa = r_full;
                w_req.opb = r_x;
            end
            S_DEN: begin
                w_req.opa = r_afl;
                w_req.opb = r_acc;
            end
            S_DIV: begin
                w_req.op  = OP_DIV;
                w_req.opa = r_num;
                w_req.opb = r_den;
            end
            S_UPD: begin
                w_req.op  = OP_SUB;
                w_req.opa = r_y;
                w_req.opb = r_err;
            end
            default: op_state = 1'b0;
        endcase
        w_req.go = op_state && !r_wait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_passes <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= w_rsp.done ? 1'b0 : (r_wait | w_req.go);
            if (accept) begin
                r_passes <= '0;
            end else if (r_state == S_UPD && w_rsp.done) begin
                r_passes <= r_passes + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= i_radicand;
            r_y   <= (deg_sat == '0 || i_radicand[30:0] == '0) ? 32'h0 : i_radicand;
            r_deg <= deg_sat;
            r_afl <= int_to_fp(7'(deg_sat));
            r_acc <= FP_ONE;
            r_k   <= '0;
        end else if (w_rsp.done) begin
            unique case (r_state)
                S_POW: begin
                    r_acc <= w_rsp.result;
                    r_k   <= r_k + DW'(1);
                end
                S_FULL: r_full <= w_rsp.result;
                S_NUM:  r_num  <= w_rsp.result;
                S_DEN:  r_den  <= w_rsp.result;
                S_DIV:  r_err  <= w_rsp.result;
                S_UPD: begin
                    r_y   <= w_rsp.result;
                    r_acc <= FP_ONE;
                    r_k   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_wait)
        else $error("FP unit answered without a pending request");

    a_pass_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_passes <= 4'(NEWTON_LIMIT))
        else $error("Newton pass count exceeded limit");

    a_no_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> !w_req.go)
        else $error("second FP request while one is pending");

endmodule
`default_nettype wire

// File: hdl/fnr_fpu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fnr_fpu
// Shared single-precision unit: multiply, subtract and divide with RNE
// rounding and subnormal support. Divide is restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module fnr_fpu
    import fnr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_fpu_req i_req,
    output t_fpu_rsp      o_rsp
);

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) begin
                n = 5'(27 - i);
            end
        end
        return n;
    endfunction

    // sig: lead bit at [25], 23 fraction bits, guard at [1], sticky at [0]
    function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [9:0] e,
                                            input logic [25:0] sig);
        logic signed [10:0] be;
        logic signed [10:0] tmp;
        logic [4:0]         sh;
        logic [25:0]        sv;
        logic [25:0]        lostm;
        logic [23:0]        mant;
        logic               g;
        logic               st;
        logic               inc;
        logic [30:0]        body;
        be = $signed({e[9], e}) + 11'sd127;
        if (be >= 11'sd255) begin
            body = FP_INF[30:0];
        end else if (be >= 11'sd1) begin
            mant = sig[25:2];
            g    = sig[1];
            st   = sig[0];
            inc  = g & (st | mant[0]);
            body = {be[7:0], mant[22:0]} + 31'(inc);
        end else begin
            tmp   = 11'sd1 - be;
            sh    = (tmp > 11'sd26) ? 5'd26 : tmp[4:0];
            sv    = sig >> sh;
            lostm = (26'(1) << sh) - 26'(1);
            sv[0] = sv[0] | (|(sig & lostm));
            mant  = sv[25:2];
            g     = sv[1];
            st    = sv[0];
            inc   = g & (st | mant[0]);
            body  = {8'h00, mant[22:0]} + 31'(inc);
        end
        return {sgn, body};
    endfunction

    t_fpu_state r_state, n_state;
    t_fpu_op    r_op;
    logic [31:0] r_a, r_b;
    logic        r_sa, r_sb;
    logic signed [9:0] r_ea, r_eb;
    logic [23:0] r_ma, r_mb;
    logic        r_spec;
    logic [31:0] r_spec_val;
    logic [47:0] r_prod;
    logic [27:0] r_sum;
    logic        r_sbig;
    logic signed [9:0] r_ebig;
    logic [25:0] r_quo;
    logic [24:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_zero;
    logic        r_rsign;
    logic signed [9:0] r_exp;
    logic [25:0] r_sig;
    logic [31:0] r_res;
    logic        r_done;

    // ---- unpack ----
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sbe, sx;
    logic [23:0] mra, mrb, mna, mnb;
    logic [4:0]  lza, lzb;
    logic signed [9:0] era, erb;
    logic        spec;
    logic [31:0] spec_val;

    always_comb begin
        nan_a  = (r_a[30:23] == 8'hFF) && (r_a[22:0] != '0);
        nan_b  = (r_b[30:23] == 8'hFF) && (r_b[22:0] != '0);
        inf_a  = (r_a[30:0] == FP_INF[30:0]);
        inf_b  = (r_b[30:0] == FP_INF[30:0]);
        zero_a = (r_a[30:0] == '0);
        zero_b = (r_b[30:0] == '0);
        sbe    = (r_op == OP_SUB) ? ~r_b[31] : r_b[31];
        sx     = r_a[31] ^ r_b[31];
        mra    = {r_a[30:23] != '0, r_a[22:0]};
        mrb    = {r_b[30:23] != '0, r_b[22:0]};
        lza    = lzc24(mra);
        lzb    = lzc24(mrb);
        mna    = mra << lza;
        mnb    = mrb << lzb;
        era    = ((r_a[30:23] == '0) ? -10'sd126 : $signed({2'b00, r_a[30:23]}) - 10'sd127)
                 - $signed({5'b0, lza});
        erb    = ((r_b[30:23] == '0) ? -10'sd126 : $signed({2'b00, r_b[30:23]}) - 10'sd127)
                 - $signed({5'b0, lzb});
        spec     = 1'b1;
        spec_val = '0;
        unique case (r_op)
            OP_MUL: begin
                if (nan_a) spec_val = r_a | FP_QUIET_BIT;
                else if (nan_b) spec_val = r_b | FP_QUIET_BIT;
                else if ((inf_a && zero_b) || (zero_a && inf_b)) spec_val = FP_QNAN_DEF;
                else if (inf_a || inf_b) spec_val = {sx, FP_INF[30:0]};
                else if (zero_a || zero_b) spec_val = {sx, 31'h0};
                else spec = 1'b0;
            end
            OP_SUB: begin
                if (nan_a) spec_val = r_a | FP_QUIET_BIT;
                else if (nan_b) spec_val = r_b | FP_QUIET_BIT;
                else if (inf_a && inf_b && (r_a[31] != sbe)) spec_val = FP_QNAN_DEF;
                else if (inf_a) spec_val = r_a;
                else if (inf_b) spec_val = {sbe, FP_INF[30:0]};
                else if (zero_a && zero_b) spec_val = {r_a[31] & sbe, 31'h0};
                else if (zero_a) spec_val = {sbe, r_b[30:0]};
                else if (zero_b) spec_val = r_a;
                else spec = 1'b0;
            end
            OP_DIV: begin
                if (zero_b) spec_val = (nan_a || zero_a) ? FP_QNAN_POS : {sx, FP_INF[30:0]};
                else if (nan_a) spec_val = r_a | FP_QUIET_BIT;
                else if (nan_b) spec_val = r_b | FP_QUIET_BIT;
                else if (inf_a && inf_b) spec_val = FP_QNAN_DEF;
                else if (inf_a) spec_val = {sx, FP_INF[30:0]};
                else if (inf_b || zero_a) spec_val = {sx, 31'h0};
                else spec = 1'b0;
            end
            default: spec = 1'b1;
        endcase
    end

    // ---- align and add ----
    logic        a_big;
    logic signed [9:0] eb_big, eb_small, ediff;
    logic [23:0] mb_big, mb_small;
    logic        s_big, s_small;
    logic [4:0]  dcl;
    logic [26:0] xs_full, xs_sh, xs_mask, xs;
    logic [27:0] sum;

    always_comb begin
        a_big    = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
        eb_big   = a_big ? r_ea : r_eb;
        eb_small = a_big ? r_eb : r_ea;
        mb_big   = a_big ? r_ma : r_mb;
        mb_small = a_big ? r_mb : r_ma;
        s_big    = a_big ? r_sa : r_sb;
        s_small  = a_big ? r_sb : r_sa;
        ediff    = eb_big - eb_small;
        dcl      = (ediff > 10'sd27) ? 5'd27 : ediff[4:0];
        xs_full  = {mb_small, 3'b000};
        xs_sh    = xs_full >> dcl;
        xs_mask  = (27'(1) << dcl) - 27'(1);
        xs       = {xs_sh[26:1], xs_sh[0] | (|(xs_full & xs_mask))};
        if (s_big == s_small) begin
            sum = {1'b0, mb_big, 3'b000} + {1'b0, xs};
        end else begin
            sum = {1'b0, mb_big, 3'b000} - {1'b0, xs};
        end
    end

    // ---- divide step ----
    logic        dv_ge;
    logic [24:0] dv_diff;

    always_comb begin
        dv_ge   = r_rem >= {1'b0, r_mb};
        dv_diff = dv_ge ? (r_rem - {1'b0, r_mb}) : r_rem;
    end

    // ---- normalize ----
    logic [4:0]  nlz;
    logic [27:0] nsum;
    logic        dsticky;

    always_comb begin
        nlz     = lzc28(r_sum);
        nsum    = r_sum << nlz;
        dsticky = (r_rem != '0);
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:   if (i_req.go) n_state = F_UNPACK;
            F_UNPACK: n_state = spec ? F_ROUND : F_EXEC;
            F_EXEC:   if (r_op != OP_DIV || r_cnt == 5'(DIV_STEPS - 1)) n_state = F_NORM;
            F_NORM:   n_state = F_ROUND;
            F_ROUND:  n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    // ---- outputs ----
    always_comb begin
        o_rsp.done   = r_done;
        o_rsp.result = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == F_ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_req.go) begin
                    r_op <= i_req.op;
                    r_a  <= i_req.opa;
                    r_b  <= i_req.opb;
                end
            end
            F_UNPACK: begin
                r_spec     <= spec;
                r_spec_val <= spec_val;
                r_sa       <= r_a[31];
                r_sb       <= sbe;
                r_ea       <= era;
                r_eb       <= erb;
                r_ma       <= mna;
                r_mb       <= mnb;
                r_rem      <= {1'b0, mna};
                r_cnt      <= '0;
                r_zero     <= 1'b0;
            end
            F_EXEC: begin
                r_prod <= r_ma * r_mb;
                r_sum  <= sum;
                r_sbig <= s_big;
                r_ebig <= eb_big;
                // exact cancellation only matters for a subtract
                r_zero <= (r_op == OP_SUB) && (sum == '0);
                if (r_op == OP_DIV) begin
                    r_zero <= 1'b0;
                    r_quo  <= {r_quo[24:0], dv_ge};
                    r_rem  <= {dv_diff[23:0], 1'b0};
                    r_cnt  <= r_cnt + 5'd1;
                end
            end
            F_NORM: begin
                unique case (r_op)
                    OP_MUL: begin
                        r_rsign <= r_sa ^ r_sb;
                        if (r_prod[47]) begin
                            r_sig <= {r_prod[47:23], |r_prod[22:0]};
                            r_exp <= r_ea + r_eb + 10'sd1;
                        end else begin
                            r_sig <= {r_prod[46:22], |r_prod[21:0]};
                            r_exp <= r_ea + r_eb;
                        end
                    end
                    OP_DIV: begin
                        r_rsign <= r_sa ^ r_sb;
                        if (r_quo[25]) begin
                            r_sig <= {r_quo[25:1], r_quo[0] | dsticky};
                            r_exp <= r_ea - r_eb;
                        end else begin
                            r_sig <= {r_quo[24:0], dsticky};
                            r_exp <= r_ea - r_eb - 10'sd1;
                        end
                    end
                    default: begin
                        r_rsign <= r_sbig;
                        r_sig   <= {nsum[27:3], |nsum[2:0]};
                        r_exp   <= r_ebig + 10'sd1 - $signed({5'b0, nlz});
                    end
                endcase
            end
            F_ROUND: begin
                if (r_spec) begin
                    r_res <= r_spec_val;
                end else if (r_zero) begin
                    r_res <= '0;
                end else begin
                    r_res <= fp_pack(r_rsign, r_exp, r_sig);
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire
